FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL modules of the noise excitation packer.
// Expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`endif

FILE: sv/nedcp_pkg.sv
// Package for the noise excitation and delta capture packer.
// Holds field widths, register indexes, result kinds and fixed-point constants.
`default_nettype none

package nedcp_pkg;

  localparam int unsigned RANDOM_W  = 32;
  localparam int unsigned ADC_W     = 36;
  localparam int unsigned PINS_W    = 3;
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NOISE_W   = 12;
  localparam int unsigned DECAY_W   = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned TICK_W    = 5;
  localparam int unsigned PCNT_W    = 8;

  localparam logic [7:0] PKT_MAGIC = 8'hA1;

  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'hFFFF;

  localparam logic signed [31:0] ONE_Q16     = 32'sh0001_0000;
  localparam logic signed [31:0] NEG_ONE_Q16 = -32'sh0001_0000;
  localparam logic signed [33:0] ONE_Q16_W   = 34'sh0_0001_0000;
  localparam logic signed [31:0] AVG_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] AVG_MIN     = 32'sh8000_0000;

  typedef enum logic [1:0] {
    KIND_DRIVE  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_DATA   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_ANALOG  = 8'd0,
    REG_USE_AVERAGE = 8'd1,
    REG_NOISE_LEVEL = 8'd2,
    REG_DECAY_COEF  = 8'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

FILE: sv/noise_excite_delta_capture_packer.sv
// Noise excitation and delta capture packer, top level.
// A tick is captured in the input register, then its drive word in the output register.
// Throughput: one tick per clock unless the output stalls; a tick that closes a 32-tick
// word holds the input while its packet streams out of the output register.
// Reset is asynchronous, active low: all channel words, averages and counters clear,
// and the registers return to analog mode, averaging on, zero noise level, full decay.
`default_nettype none

module noise_excite_delta_capture_packer #(
  parameter int unsigned NUM_INPUTS  = 3,
  parameter int unsigned NUM_OUTPUTS = 4,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // Fields from bit 0: random_word[31:0], adc_samples[67:32], digital_pins[70:68].
  input  wire logic [nedcp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Output stream.
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // Fields from bit 0: data[31:0].
  output      logic [nedcp_pkg::WORD_W-1:0]    m_axis_tdata,
  // Fields from bit 0: kind[1:0].
  output      logic [1:0]                      m_axis_tuser,
  output      logic                            m_axis_tlast,
  // Configuration write channel.
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [nedcp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [nedcp_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import nedcp_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned PktWords = 1 + NUM_INPUTS + NUM_OUTPUTS;
  localparam int unsigned IdxW     = $clog2(PktWords);
  localparam int unsigned DiffW    = ((SAMPLE_BITS > NOISE_W) ? SAMPLE_BITS : NOISE_W) + 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PktWords - 1);

  // Configuration registers.
  logic               use_analog_q;
  logic               use_average_q;
  logic [NOISE_W-1:0] noise_level_q;
  logic [DECAY_W-1:0] decay_coef_q;

  // Input register.
  logic                in_valid_q;
  logic [RANDOM_W-1:0] in_random_q;
  logic [ADC_W-1:0]    in_adc_q;
  logic [PINS_W-1:0]   in_pins_q;

  // Channel state.
  logic        [SAMPLE_BITS-1:0] prev_sample_q [NUM_INPUTS];
  logic        [SAMPLE_BITS-1:0] prev_sample_d [NUM_INPUTS];
  logic        [WORD_W-1:0]      in_bits_q     [NUM_INPUTS];
  logic        [WORD_W-1:0]      in_bits_d     [NUM_INPUTS];
  logic        [WORD_W-1:0]      out_bits_q    [NUM_OUTPUTS];
  logic        [WORD_W-1:0]      out_bits_d    [NUM_OUTPUTS];
  logic signed [31:0]            avg_q         [NUM_OUTPUTS];
  logic signed [31:0]            avg_d         [NUM_OUTPUTS];
  logic        [TICK_W-1:0]      tick_cnt_q;
  logic        [PCNT_W-1:0]      pkt_cnt_q;

  // Packet sequencer and output register.
  logic              pkt_busy_q, pkt_busy_d;
  logic [IdxW-1:0]   pkt_idx_q, pkt_idx_d;
  logic              m_valid_q, m_valid_d;
  logic [WORD_W-1:0] m_data_q, m_data_d;
  kind_e             m_kind_q, m_kind_d;
  logic              m_last_q, m_last_d;

  logic              out_free;
  logic              process;
  logic              load_pkt;
  logic              tick_wrap;
  logic [WORD_W-1:0] drive_word;
  logic [WORD_W-1:0] pkt_word [PktWords];

  assign cfg_ready_o = 1'b1;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign load_pkt      = pkt_busy_q && out_free;
  assign process       = in_valid_q && !pkt_busy_q && out_free;
  assign s_axis_tready = !in_valid_q || process;
  assign tick_wrap     = (tick_cnt_q == {TICK_W{1'b1}});

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_analog_q  <= 1'b1;
      use_average_q <= 1'b1;
      noise_level_q <= '0;
      decay_coef_q  <= DECAY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_USE_ANALOG:  use_analog_q  <= cfg_data_i[0];
        REG_USE_AVERAGE: use_average_q <= cfg_data_i[0];
        REG_NOISE_LEVEL: noise_level_q <= cfg_data_i[NOISE_W-1:0];
        REG_DECAY_COEF:  decay_coef_q  <= cfg_data_i[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_random_q <= s_axis_tdata[RANDOM_W-1:0];
      in_adc_q    <= s_axis_tdata[RANDOM_W +: ADC_W];
      in_pins_q   <= s_axis_tdata[RANDOM_W+ADC_W +: PINS_W];
    end
  end

  // Drive bits and leaky balance averages, one lane per output channel.
  always_comb begin
    logic              rbit;
    logic              obit;
    logic signed [48:0] prod;
    logic signed [33:0] nv;
    drive_word = '0;
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      rbit = in_random_q[k];
      prod = avg_q[k] * $signed({1'b0, decay_coef_q});
      if (use_average_q) begin
        obit = rbit ? (avg_q[k] < ONE_Q16) : (avg_q[k] < NEG_ONE_Q16);
        nv   = $signed({prod[48], prod[48:16]}) + (obit ? ONE_Q16_W : -ONE_Q16_W);
        if (nv[33:31] == 3'b000 || nv[33:31] == 3'b111) begin
          avg_d[k] = nv[31:0];
        end else if (nv[33]) begin
          avg_d[k] = AVG_MIN;
        end else begin
          avg_d[k] = AVG_MAX;
        end
      end else begin
        obit     = rbit;
        nv       = '0;
        avg_d[k] = avg_q[k];
      end
      out_bits_d[k] = {out_bits_q[k][WORD_W-2:0], obit};
      drive_word[k] = obit;
    end
  end

  // Capture bits, one lane per input channel.
  always_comb begin
    logic [SAMPLE_BITS-1:0]   smp;
    logic signed [DiffW-1:0]  diff;
    logic signed [DiffW-1:0]  nl;
    logic                     ibit;
    nl = $signed({{(DiffW-NOISE_W){1'b0}}, noise_level_q});
    for (int i = 0; i < NUM_INPUTS; i++) begin
      smp  = SAMPLE_BITS'(in_adc_q >> (SAMPLE_BITS * i));
      diff = $signed({{(DiffW-SAMPLE_BITS){1'b0}}, smp})
           - $signed({{(DiffW-SAMPLE_BITS){1'b0}}, prev_sample_q[i]});
      if (use_analog_q) begin
        if (diff < nl && diff > -nl) begin
          ibit = in_bits_q[i][0];
        end else begin
          ibit = (smp > prev_sample_q[i]);
        end
        prev_sample_d[i] = smp;
      end else begin
        ibit             = in_pins_q[i];
        prev_sample_d[i] = prev_sample_q[i];
      end
      in_bits_d[i] = {in_bits_q[i][WORD_W-2:0], ibit};
    end
  end

  always_comb begin
    pkt_word[0] = {8'(NUM_OUTPUTS), 8'(NUM_INPUTS), pkt_cnt_q, PKT_MAGIC};
    for (int i = 0; i < NUM_INPUTS; i++) begin
      pkt_word[1+i] = in_bits_q[i];
    end
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      pkt_word[1+NUM_INPUTS+k] = out_bits_q[k];
    end
  end

  always_comb begin
    pkt_busy_d = pkt_busy_q;
    pkt_idx_d  = pkt_idx_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_kind_d   = m_kind_q;
    m_last_d   = m_last_q;
    priority if (load_pkt) begin
      m_valid_d = 1'b1;
      m_data_d  = pkt_word[pkt_idx_q];
      m_kind_d  = (pkt_idx_q == '0) ? KIND_HEADER : KIND_DATA;
      m_last_d  = (pkt_idx_q == LastIdx);
      pkt_idx_d = pkt_idx_q + 1'b1;
      if (pkt_idx_q == LastIdx) begin
        pkt_busy_d = 1'b0;
      end
    end else if (process) begin
      m_valid_d  = 1'b1;
      m_data_d   = drive_word;
      m_kind_d   = KIND_DRIVE;
      m_last_d   = !tick_wrap;
      pkt_busy_d = tick_wrap;
      pkt_idx_d  = '0;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
        prev_sample_q[i] <= '0;
        in_bits_q[i]     <= '0;
      end
      for (int k = 0; k < NUM_OUTPUTS; k++) begin
        out_bits_q[k] <= '0;
        avg_q[k]      <= '0;
      end
      tick_cnt_q <= '0;
    end else if (process) begin
      prev_sample_q <= prev_sample_d;
      in_bits_q     <= in_bits_d;
      out_bits_q    <= out_bits_d;
      avg_q         <= avg_d;
      tick_cnt_q    <= tick_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q  <= '0;
      pkt_busy_q <= 1'b0;
      pkt_idx_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (load_pkt && pkt_idx_q == LastIdx) begin
        pkt_cnt_q <= pkt_cnt_q + 1'b1;
      end
      pkt_busy_q <= pkt_busy_d;
      pkt_idx_q  <= pkt_idx_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_kind_q <= m_kind_d;
    m_last_q <= m_last_d;
  end

  `ASSERT_CLK(a_pkt_on_wrap, pkt_busy_q |-> tick_cnt_q == '0)
  `ASSERT_NEVER(a_no_accept_in_pkt, pkt_busy_q && in_valid_q && s_axis_tready)
  `ASSERT_NEVER(a_header_not_last, m_valid_q && m_kind_q == KIND_HEADER && m_last_q)
  `ASSERT_CLK(a_drive_then_pkt,
    m_valid_q && m_axis_tready && m_kind_q == KIND_DRIVE && !m_last_q |=> pkt_busy_q)

endmodule

`default_nettype wire
